>>> design/jfps_pkg.sv
package jfps_pkg;

    localparam int PAGE_BYTES      = 256;
    localparam int PAGE_SHIFT      = $clog2(PAGE_BYTES);
    localparam int BLOCK_BYTES     = 65536;
    localparam int BLOCK_SHIFT     = $clog2(BLOCK_BYTES);
    localparam int WINDOW_MAX      = 16;
    localparam int WINDOW_DEFAULT  = 4;
    localparam int PROGRESS_PAGES  = 256;
    localparam int MAX_IMAGE_BYTES = 16777216;
    localparam int WIN_W           = $clog2(WINDOW_MAX + 1);
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [12:0] TMO_PAGE  = 13'd1000;
    localparam logic [12:0] TMO_LONG  = 13'd5000;
    localparam logic [12:0] TMO_DELAY = 13'd100;
    localparam logic [12:0] TMO_NONE  = 13'd0;

    localparam logic [1:0] REQ_PROGRAM = 2'd0;
    localparam logic [1:0] REQ_REPLY   = 2'd1;
    localparam logic [1:0] REQ_DELAY   = 2'd2;
    localparam logic [1:0] REQ_ABORT   = 2'd3;

    localparam logic [2:0] KIND_MEM      = 3'd0;
    localparam logic [2:0] KIND_MODE     = 3'd1;
    localparam logic [2:0] KIND_LINK     = 3'd2;
    localparam logic [2:0] KIND_DELAY    = 3'd3;
    localparam logic [2:0] KIND_PROGRESS = 3'd4;
    localparam logic [2:0] KIND_STATUS   = 3'd5;

    localparam logic [2:0] OP_READ  = 3'd0;
    localparam logic [2:0] OP_WRITE = 3'd1;
    localparam logic [2:0] OP_ERASE = 3'd2;
    localparam logic [2:0] OP_OPEN  = 3'd3;
    localparam logic [2:0] OP_CLOSE = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BUSY    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_IO      = 2'd3;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_PROG   = 2'd2;
    localparam logic [1:0] LINK_OFF    = 2'd0;
    localparam logic [1:0] LINK_ON     = 2'd1;
    localparam logic [1:0] PH_ERASE    = 2'd0;
    localparam logic [1:0] PH_WRITE    = 2'd1;
    localparam logic [1:0] PH_VERIFY   = 2'd2;

    typedef enum logic [3:0] {
        P_IDLE, P_MODE_SWITCH, P_OPEN, P_ERASE, P_WRITE, P_VERIFY, P_CLOSE, P_MODE_RESTORE
    } t_phase;

    typedef enum logic [4:0] {
        ACT_IDLE, ACT_DECIDE, ACT_PAGES, ACT_STATUS, ACT_LINK_OFF, ACT_MODE_PROG,
        ACT_DELAY, ACT_OPEN, ACT_ERASE, ACT_PROG_ERASE, ACT_SEND, ACT_PROG_PAGE,
        ACT_CLOSE, ACT_MODE_NORM, ACT_LINK_ON, ACT_FINAL, ACT_ABORT
    } t_act;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [31:0]      tid;
        logic             format_ok;
        logic             bad_req;
        logic [WIN_W-1:0] win;
        logic [24:0]      bytes;
        logic [16:0]      pages;
        logic             reply_error;
        logic             too_short;
        logic             mismatch;
    } t_ev;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  mem_op;
        logic [23:0] offset;
        logic [16:0] length;
        logic [12:0] tmo_ms;
        logic [31:0] cmd_id;
        logic [1:0]  arg;
        logic [16:0] cur;
        logic [16:0] tot;
        logic [1:0]  status;
        logic [31:0] echo_id;
        logic        last;
    } t_res;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

>>> design/jfps_front.sv
module jfps_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [1:0]      i_req_type,
    input  logic [31:0]     i_transaction_id,
    input  logic            i_op_is_program,
    input  logic            i_format_ok,
    input  logic [24:0]     i_image_bytes,
    input  logic [7:0]      i_window_request,
    input  logic            i_reply_error,
    input  logic            i_reply_too_short,
    input  logic            i_reply_mismatch,
    input  jfps_pkg::t_qstat i_qstat,
    output logic            o_push,
    output jfps_pkg::t_ev   o_ev
);
    import jfps_pkg::*;

    logic r_fv;
    t_ev  r_ev;
    t_ev  n_ev;
    logic bad_size;

    assign o_stall = r_fv && i_qstat.full;
    assign o_push  = r_fv && !i_qstat.full;
    assign o_ev    = r_ev;

    always_comb begin
        bad_size = (i_image_bytes == 25'd0) || (i_image_bytes > 25'(MAX_IMAGE_BYTES));
        n_ev.req_type    = i_req_type;
        n_ev.tid         = i_transaction_id;
        n_ev.format_ok   = i_format_ok;
        n_ev.bad_req     = !i_op_is_program || bad_size;
        if (i_window_request == 8'd0) begin
            n_ev.win = WIN_W'(WINDOW_DEFAULT);
        end else if (i_window_request > 8'(WINDOW_MAX)) begin
            n_ev.win = WIN_W'(WINDOW_MAX);
        end else begin
            n_ev.win = WIN_W'(i_window_request);
        end
        n_ev.bytes       = i_image_bytes;
        n_ev.pages       = 17'((26'(i_image_bytes) + 26'(PAGE_BYTES - 1)) >> PAGE_SHIFT);
        n_ev.reply_error = i_reply_error;
        n_ev.too_short   = i_reply_too_short;
        n_ev.mismatch    = i_reply_mismatch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (!o_stall) begin
            r_fv <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_ev <= n_ev;
        end
    end

endmodule

>>> design/jfps_queue.sv
module jfps_queue #(
    parameter int DEPTH = jfps_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  jfps_pkg::t_ev    i_ev,
    input  logic             i_pop,
    output jfps_pkg::t_ev    o_ev,
    output jfps_pkg::t_qstat o_qstat
);
    import jfps_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_ev           r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_pop;

    assign o_qstat.full  = (r_cnt == CW'(DEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign o_ev          = r_mem[r_rp];
    assign do_pop        = i_pop && !o_qstat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_ev;
        end
    end

endmodule

>>> design/jfps_back.sv
module jfps_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  jfps_pkg::t_qstat i_qstat,
    input  jfps_pkg::t_ev    i_ev,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output jfps_pkg::t_res   o_res
);
    import jfps_pkg::*;

    t_phase           r_phase;
    t_act             r_act;
    t_act             n_act;
    t_ev              r_ev;
    logic [31:0]      r_cnt;
    logic [31:0]      r_saved;
    logic [WIN_W-1:0] r_win;
    logic [24:0]      r_img;
    logic [16:0]      r_tot;
    logic [16:0]      r_sent;
    logic [16:0]      r_acked;
    logic             r_err;
    logic [8:0]       r_blk_tot;
    logic [8:0]       r_blk_done;
    logic [1:0]       r_status;
    logic [31:0]      r_echo;
    logic             r_ovalid;
    t_res             r_out;

    t_res        res;
    logic        emit;
    logic        slot;
    logic        send_ok;
    logic        send_more;
    logic        pg_done;
    logic        prog_tick;
    logic        blk_last;
    logic        e_any;
    logic [16:0] sent_inc;

    assign slot      = !r_ovalid || !i_stall;
    assign o_pop     = (r_act == ACT_IDLE) && !i_qstat.empty;
    assign o_valid   = r_ovalid;
    assign o_res     = r_out;
    assign sent_inc  = r_sent + 17'd1;
    assign send_ok   = (r_sent < r_tot) && ((r_sent - r_acked) < 17'(r_win));
    assign send_more = (sent_inc < r_tot) && ((sent_inc - r_acked) < 17'(r_win));
    assign pg_done   = r_acked >= r_tot;
    assign prog_tick = (r_acked & 17'(PROGRESS_PAGES - 1)) == 17'd0;
    assign blk_last  = r_blk_done >= r_blk_tot;
    assign e_any     = r_err || r_ev.reply_error;

    // next action
    always_comb begin
        n_act = r_act;
        case (r_act)
            ACT_IDLE: if (!i_qstat.empty) n_act = ACT_DECIDE;
            ACT_DECIDE: begin
                case (r_ev.req_type)
                    REQ_PROGRAM: begin
                        if (r_phase != P_IDLE || !r_ev.format_ok || r_ev.bad_req) begin
                            n_act = ACT_STATUS;
                        end else begin
                            n_act = ACT_LINK_OFF;
                        end
                    end
                    REQ_REPLY: begin
                        n_act = ACT_IDLE;
                        if (!r_ev.too_short) begin
                            case (r_phase)
                                P_OPEN:   n_act = e_any ? ACT_CLOSE : ACT_ERASE;
                                P_ERASE:  n_act = e_any ? ACT_CLOSE : ACT_PROG_ERASE;
                                P_WRITE:  n_act = ACT_PAGES;
                                P_VERIFY: n_act = ACT_PAGES;
                                P_CLOSE:  n_act = ACT_MODE_NORM;
                                default:  n_act = ACT_IDLE;
                            endcase
                        end
                    end
                    REQ_DELAY: begin
                        case (r_phase)
                            P_MODE_SWITCH:  n_act = ACT_OPEN;
                            P_MODE_RESTORE: n_act = ACT_LINK_ON;
                            default:        n_act = ACT_IDLE;
                        endcase
                    end
                    default: n_act = (r_phase != P_IDLE) ? ACT_ABORT : ACT_IDLE;
                endcase
            end
            ACT_PAGES: begin
                if (r_err) begin
                    n_act = (r_acked >= r_sent) ? ACT_CLOSE : ACT_IDLE;
                end else if (pg_done || prog_tick) begin
                    n_act = ACT_PROG_PAGE;
                end else begin
                    n_act = send_ok ? ACT_SEND : ACT_IDLE;
                end
            end
            ACT_STATUS:     if (slot) n_act = ACT_IDLE;
            ACT_LINK_OFF:   if (slot) n_act = ACT_MODE_PROG;
            ACT_MODE_PROG:  if (slot) n_act = ACT_DELAY;
            ACT_DELAY:      if (slot) n_act = ACT_IDLE;
            ACT_OPEN:       if (slot) n_act = ACT_IDLE;
            ACT_ERASE:      if (slot) n_act = ACT_IDLE;
            ACT_PROG_ERASE: if (slot) n_act = blk_last ? ACT_SEND : ACT_ERASE;
            ACT_SEND:       if (slot) n_act = send_more ? ACT_SEND : ACT_IDLE;
            ACT_PROG_PAGE: begin
                if (slot) begin
                    if (pg_done) begin
                        n_act = (r_phase == P_WRITE) ? ACT_SEND : ACT_CLOSE;
                    end else begin
                        n_act = send_ok ? ACT_SEND : ACT_IDLE;
                    end
                end
            end
            ACT_CLOSE:      if (slot) n_act = ACT_IDLE;
            ACT_MODE_NORM:  if (slot) n_act = ACT_DELAY;
            ACT_LINK_ON:    if (slot) n_act = ACT_FINAL;
            ACT_FINAL:      if (slot) n_act = ACT_IDLE;
            ACT_ABORT:      if (slot) n_act = ACT_IDLE;
            default:        n_act = ACT_IDLE;
        endcase
    end

    // result produced by the current action
    always_comb begin
        res  = '0;
        emit = 1'b1;
        case (r_act)
            ACT_STATUS: begin
                res.kind    = KIND_STATUS;
                res.status  = r_status;
                res.echo_id = r_echo;
                res.last    = 1'b1;
            end
            ACT_LINK_OFF: begin
                res.kind = KIND_LINK;
                res.arg  = LINK_OFF;
            end
            ACT_MODE_PROG: begin
                res.kind = KIND_MODE;
                res.arg  = MODE_PROG;
            end
            ACT_DELAY: begin
                res.kind   = KIND_DELAY;
                res.tmo_ms = TMO_DELAY;
                res.last   = 1'b1;
            end
            ACT_OPEN: begin
                res.kind   = KIND_MEM;
                res.mem_op = OP_OPEN;
                res.tmo_ms = TMO_LONG;
                res.cmd_id = r_cnt + 32'd1;
                res.last   = 1'b1;
            end
            ACT_ERASE: begin
                res.kind   = KIND_MEM;
                res.mem_op = OP_ERASE;
                res.offset = 24'(32'(r_blk_done) << BLOCK_SHIFT);
                res.length = 17'(BLOCK_BYTES);
                res.tmo_ms = TMO_LONG;
                res.cmd_id = r_cnt + 32'd1;
                res.last   = 1'b1;
            end
            ACT_PROG_ERASE: begin
                res.kind = KIND_PROGRESS;
                res.arg  = PH_ERASE;
                res.cur  = 17'(r_blk_done);
                res.tot  = 17'(r_blk_tot);
            end
            ACT_SEND: begin
                res.kind   = KIND_MEM;
                res.mem_op = (r_phase == P_WRITE) ? OP_WRITE : OP_READ;
                res.offset = 24'(32'(r_sent) << PAGE_SHIFT);
                res.length = 17'(PAGE_BYTES);
                res.tmo_ms = TMO_PAGE;
                res.cmd_id = r_cnt + 32'd1;
                res.last   = !send_more;
            end
            ACT_PROG_PAGE: begin
                res.kind = KIND_PROGRESS;
                res.arg  = (r_phase == P_WRITE) ? PH_WRITE : PH_VERIFY;
                res.cur  = r_acked;
                res.tot  = r_tot;
                res.last = !pg_done && !send_ok;
            end
            ACT_CLOSE: begin
                res.kind   = KIND_MEM;
                res.mem_op = OP_CLOSE;
                res.tmo_ms = TMO_LONG;
                res.cmd_id = r_cnt + 32'd1;
                res.last   = 1'b1;
            end
            ACT_MODE_NORM: begin
                res.kind = KIND_MODE;
                res.arg  = MODE_NORMAL;
            end
            ACT_LINK_ON: begin
                res.kind = KIND_LINK;
                res.arg  = LINK_ON;
            end
            ACT_FINAL: begin
                res.kind    = KIND_STATUS;
                res.status  = r_err ? ST_IO : ST_OK;
                res.echo_id = r_saved;
                res.last    = 1'b1;
            end
            ACT_ABORT: begin
                res.kind   = KIND_DELAY;
                res.tmo_ms = TMO_NONE;
                res.last   = 1'b1;
            end
            default: emit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act      <= ACT_IDLE;
            r_phase    <= P_IDLE;
            r_cnt      <= '0;
            r_saved    <= '0;
            r_win      <= '0;
            r_img      <= '0;
            r_tot      <= '0;
            r_sent     <= '0;
            r_acked    <= '0;
            r_err      <= 1'b0;
            r_blk_tot  <= '0;
            r_blk_done <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_act <= n_act;
            if (slot) begin
                r_ovalid <= emit;
            end
            case (r_act)
                ACT_DECIDE: begin
                    case (r_ev.req_type)
                        REQ_PROGRAM: begin
                            if (r_phase != P_IDLE) begin
                                r_saved <= r_ev.tid;
                            end else if (r_ev.format_ok) begin
                                r_saved <= r_ev.tid;
                                r_win   <= r_ev.win;
                                r_err   <= 1'b0;
                                if (!r_ev.bad_req) begin
                                    r_img   <= r_ev.bytes;
                                    r_tot   <= r_ev.pages;
                                    r_phase <= P_MODE_SWITCH;
                                end
                            end
                        end
                        REQ_REPLY: begin
                            if (r_phase != P_IDLE && !r_ev.too_short) begin
                                if (r_ev.reply_error) begin
                                    r_err <= 1'b1;
                                end
                                case (r_phase)
                                    P_OPEN: begin
                                        if (!e_any) begin
                                            r_blk_tot  <= 9'((26'(r_img) + 26'(BLOCK_BYTES - 1))
                                                          >> BLOCK_SHIFT);
                                            r_blk_done <= '0;
                                            r_sent     <= '0;
                                            r_acked    <= '0;
                                            r_phase    <= P_ERASE;
                                        end
                                    end
                                    P_ERASE: if (!e_any) r_blk_done <= r_blk_done + 9'd1;
                                    P_WRITE: r_acked <= r_acked + 17'd1;
                                    P_VERIFY: begin
                                        r_acked <= r_acked + 17'd1;
                                        if (r_ev.mismatch && !e_any) begin
                                            r_err <= 1'b1;
                                        end
                                    end
                                    P_CLOSE: r_phase <= P_MODE_RESTORE;
                                    default: ;
                                endcase
                            end
                        end
                        REQ_DELAY: begin
                            if (r_phase == P_MODE_SWITCH) begin
                                r_phase <= P_OPEN;
                            end
                        end
                        default: begin
                            r_phase <= P_IDLE;
                            r_img   <= '0;
                            r_tot   <= '0;
                            r_sent  <= '0;
                            r_acked <= '0;
                            r_err   <= 1'b0;
                        end
                    endcase
                end
                ACT_OPEN, ACT_ERASE: if (slot) r_cnt <= r_cnt + 32'd1;
                ACT_SEND: begin
                    if (slot) begin
                        r_cnt  <= r_cnt + 32'd1;
                        r_sent <= sent_inc;
                    end
                end
                ACT_CLOSE: begin
                    if (slot) begin
                        r_cnt   <= r_cnt + 32'd1;
                        r_phase <= P_CLOSE;
                    end
                end
                ACT_PROG_ERASE: begin
                    if (slot && blk_last) begin
                        r_phase <= P_WRITE;
                        r_sent  <= '0;
                        r_acked <= '0;
                    end
                end
                ACT_PROG_PAGE: begin
                    if (slot && pg_done && r_phase == P_WRITE) begin
                        r_phase <= P_VERIFY;
                        r_sent  <= '0;
                        r_acked <= '0;
                    end
                end
                ACT_FINAL: begin
                    if (slot) begin
                        r_phase <= P_IDLE;
                        r_img   <= '0;
                        r_tot   <= '0;
                        r_sent  <= '0;
                        r_acked <= '0;
                        r_err   <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ev <= i_ev;
        end
        if (slot) begin
            r_out <= res;
        end
        if (r_act == ACT_DECIDE && r_ev.req_type == REQ_PROGRAM) begin
            if (r_phase != P_IDLE) begin
                r_status <= ST_BUSY;
                r_echo   <= r_ev.tid;
            end else if (!r_ev.format_ok) begin
                r_status <= ST_INVALID;
                r_echo   <= r_saved;
            end else begin
                r_status <= ST_INVALID;
                r_echo   <= r_ev.tid;
            end
        end
    end

endmodule

>>> design/jtag_flash_program_sequencer_core.sv
// Flash program sequencer. The front stage registers each item, checks and
// clamps the request fields, and pushes it into a QUEUE_DEPTH-entry queue;
// the back end pops one item at a time, decodes it (page replies take an
// extra ACT_PAGES step) and then sends its results, e.g. the last write
// reply, which sends the write progress event and refills a 16-command
// window with verify reads, is 17 results. Output stalls hold the back end.
// Results leave through a single output register; o_stall only rises when
// the queue is full and the front stage holds an item.
module jtag_flash_program_sequencer_core #(
    parameter int QUEUE_DEPTH = jfps_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_transaction_id,
    input  logic        i_op_is_program,
    input  logic        i_format_ok,
    input  logic [24:0] i_image_bytes,
    input  logic [7:0]  i_window_request,
    input  logic        i_reply_error,
    input  logic        i_reply_too_short,
    input  logic        i_reply_mismatch,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic [2:0]  o_mem_op,
    output logic [23:0] o_offset,
    output logic [16:0] o_length,
    output logic [12:0] o_tmo_ms,
    output logic [31:0] o_cmd_id,
    output logic [1:0]  o_arg,
    output logic [16:0] o_progress_current,
    output logic [16:0] o_progress_total,
    output logic [1:0]  o_status,
    output logic [31:0] o_echo_id,
    output logic        o_last
);
    import jfps_pkg::*;

    t_qstat qstat;
    t_ev    front_ev;
    t_ev    queue_ev;
    t_res   res;
    logic   push;
    logic   pop;

    jfps_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_req_type        (i_req_type),
        .i_transaction_id  (i_transaction_id),
        .i_op_is_program   (i_op_is_program),
        .i_format_ok       (i_format_ok),
        .i_image_bytes     (i_image_bytes),
        .i_window_request  (i_window_request),
        .i_reply_error     (i_reply_error),
        .i_reply_too_short (i_reply_too_short),
        .i_reply_mismatch  (i_reply_mismatch),
        .i_qstat           (qstat),
        .o_push            (push),
        .o_ev              (front_ev)
    );

    jfps_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ev    (front_ev),
        .i_pop   (pop),
        .o_ev    (queue_ev),
        .o_qstat (qstat)
    );

    jfps_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (qstat),
        .i_ev    (queue_ev),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (res)
    );

    assign o_kind             = res.kind;
    assign o_mem_op           = res.mem_op;
    assign o_offset           = res.offset;
    assign o_length           = res.length;
    assign o_tmo_ms           = res.tmo_ms;
    assign o_cmd_id           = res.cmd_id;
    assign o_arg              = res.arg;
    assign o_progress_current = res.cur;
    assign o_progress_total   = res.tot;
    assign o_status           = res.status;
    assign o_echo_id          = res.echo_id;
    assign o_last             = res.last;

endmodule

>>> design/jfps_checker.sv
module jfps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_kind,
    input logic [12:0] o_tmo_ms,
    input logic [16:0] o_progress_current,
    input logic [16:0] o_progress_total,
    input logic [31:0] o_cmd_id,
    input logic        o_last
);
    import jfps_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_cmd_id))
        else $error("stalled result changed");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_STATUS |-> o_last)
        else $error("final status not marked last");

    a_mem_tmo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_MEM |-> o_tmo_ms == TMO_PAGE || o_tmo_ms == TMO_LONG)
        else $error("memory command with bad timeout");

    a_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_PROGRESS |-> o_progress_current <= o_progress_total)
        else $error("progress beyond total");

endmodule

bind jtag_flash_program_sequencer_core jfps_checker u_jfps_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_kind             (o_kind),
    .o_tmo_ms           (o_tmo_ms),
    .o_progress_current (o_progress_current),
    .o_progress_total   (o_progress_total),
    .o_cmd_id           (o_cmd_id),
    .o_last             (o_last)
);
